// ===== design/wmf_pkg.sv =====
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared types, constants and defaults of the window median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

    // default geometry
    localparam int DEF_WIN_H     = 3;
    localparam int DEF_WIN_W     = 3;
    localparam int DEF_MAX_WIDTH = 2048;

    // fixed limits and sizes
    localparam int ROW_LIMIT   = 2048;
    localparam int PIX_W       = 24;
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int POS_W       = 11;
    localparam int CFG_W       = 12;
    localparam int QUEUE_DEPTH = 4;

    // register reset values
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic             RST_COLOR_MODE   = 1'b1;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_COLOR_MODE   = 2'd2
    } t_cfg_idx;

    // per-result side information carried with each window
    typedef struct packed {
        logic [POS_W-1:0] center_row;
        logic [POS_W-1:0] center_col;
        logic             frame_end;
        logic             color_mode;
    } t_meta;

    localparam int META_W = $bits(t_meta);

endpackage

// ===== design/wmf_ram.sv =====
// ----------------------------------------------------------------------------
// wmf_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module wmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/wmf_front.sv =====
// ----------------------------------------------------------------------------
// wmf_front
// Raster counters, line stores and sliding window; pushes full windows.
// ----------------------------------------------------------------------------
module wmf_front #(
    parameter int WIN_H     = wmf_pkg::DEF_WIN_H,
    parameter int WIN_W     = wmf_pkg::DEF_WIN_W,
    parameter int MAX_WIDTH = wmf_pkg::DEF_MAX_WIDTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [wmf_pkg::PIX_W-1:0]               i_pix,
    input  logic [wmf_pkg::CFG_W-1:0]               i_frame_width,
    input  logic [wmf_pkg::CFG_W-1:0]               i_frame_height,
    input  logic                                    i_color_mode,
    input  logic                                    i_pop,
    output logic                                    o_push,
    output logic [WIN_H*WIN_W*wmf_pkg::PIX_W+wmf_pkg::META_W-1:0] o_push_data
);

    localparam int WIN_N     = WIN_H * WIN_W;
    localparam int LINE_ROWS = WIN_H - 1;
    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int QW        = $clog2(wmf_pkg::QUEUE_DEPTH + 1);
    localparam int XW        = 13;
    localparam int PW        = wmf_pkg::PIX_W;

    // raster counters and queue reservations
    logic [AW-1:0]              r_col_cnt;
    logic [wmf_pkg::POS_W-1:0]  r_row_cnt;
    logic [QW-1:0]              r_used;

    // second stage registers
    logic                       r_b_valid;
    logic                       r_b_emit;
    logic                       r_b_byp;
    logic [AW-1:0]              r_b_c;
    logic [PW-1:0]              r_b_pix;
    wmf_pkg::t_meta             r_b_meta;

    logic [PW-1:0]              r_last [LINE_ROWS];
    logic [PW-1:0]              r_win  [WIN_H][WIN_W];
    logic [PW-1:0]              n_win  [WIN_H][WIN_W];

    logic [PW-1:0]              rd   [LINE_ROWS];
    logic [PW-1:0]              col  [WIN_H];

    logic [XW-1:0]              w_eff, h_eff, cx, rx;
    logic                       accept, last_col, last_row, emit;
    logic [AW-1:0]              c_idx;
    logic [AW-1:0]              n_col_cnt;
    logic [wmf_pkg::POS_W-1:0]  n_row_cnt;
    wmf_pkg::t_meta             meta;

    assign o_in_stall = (r_used == QW'(wmf_pkg::QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    // clamp bounds and position, classify the pixel
    always_comb begin
        w_eff = {1'b0, i_frame_width};
        if (w_eff > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end
        if (w_eff == '0) begin
            w_eff = XW'(1);
        end
        h_eff = {1'b0, i_frame_height};
        if (h_eff > XW'(wmf_pkg::ROW_LIMIT)) begin
            h_eff = XW'(wmf_pkg::ROW_LIMIT);
        end
        if (h_eff == '0) begin
            h_eff = XW'(1);
        end
        cx = XW'(r_col_cnt);
        if (cx >= w_eff) begin
            cx = w_eff - XW'(1);
        end
        rx = XW'(r_row_cnt);
        if (rx >= h_eff) begin
            rx = h_eff - XW'(1);
        end
        c_idx    = cx[AW-1:0];
        last_col = (cx + XW'(1)) >= w_eff;
        last_row = (rx + XW'(1)) >= h_eff;
        emit     = ((rx + XW'(1)) >= XW'(WIN_H)) && ((cx + XW'(1)) >= XW'(WIN_W));
        meta.center_row = wmf_pkg::POS_W'(rx + XW'(WIN_H / 2) + XW'(1) - XW'(WIN_H));
        meta.center_col = wmf_pkg::POS_W'(cx + XW'(WIN_W / 2) + XW'(1) - XW'(WIN_W));
        meta.frame_end  = last_col && last_row;
        meta.color_mode = i_color_mode;
        if (last_col) begin
            n_col_cnt = '0;
            n_row_cnt = last_row ? '0 : wmf_pkg::POS_W'(rx + XW'(1));
        end else begin
            n_col_cnt = AW'(cx + XW'(1));
            n_row_cnt = wmf_pkg::POS_W'(rx);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_used    <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept;
            r_used    <= r_used + QW'(accept && emit) - QW'(i_pop);
            if (accept) begin
                r_col_cnt <= n_col_cnt;
                r_row_cnt <= n_row_cnt;
            end
        end
    end

    // payload into the second stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_emit <= emit;
            r_b_byp  <= r_b_valid && (r_b_c == c_idx);
            r_b_c    <= c_idx;
            r_b_pix  <= i_pix;
            r_b_meta <= meta;
        end
    end

    // line stores, one per buffered row
    for (genvar k = 0; k < LINE_ROWS; k++) begin : g_line
        wmf_ram #(
            .WIDTH (PW),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (r_b_valid),
            .i_waddr (r_b_c),
            .i_wdata (col[k+1]),
            .i_re    (accept),
            .i_raddr (c_idx),
            .o_rdata (rd[k])
        );
    end

    // new column, with forwarding when the previous pixel wrote the same entry
    always_comb begin
        for (int k = 0; k < LINE_ROWS; k++) begin
            col[k] = r_b_byp ? r_last[k] : rd[k];
        end
        col[WIN_H-1] = r_b_pix;
        for (int k = 0; k < WIN_H; k++) begin
            for (int x = 0; x < WIN_W - 1; x++) begin
                n_win[k][x] = r_win[k][x+1];
            end
            n_win[k][WIN_W-1] = col[k];
        end
    end

    // window shift and last written column
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_win <= n_win;
            for (int k = 0; k < LINE_ROWS; k++) begin
                r_last[k] <= col[k+1];
            end
        end
    end

    // queue request
    always_comb begin
        o_push_data = '0;
        for (int k = 0; k < WIN_H; k++) begin
            for (int x = 0; x < WIN_W; x++) begin
                o_push_data[(k*WIN_W+x)*PW +: PW] = n_win[k][x];
            end
        end
        o_push_data[WIN_N*PW +: wmf_pkg::META_W] = r_b_meta;
    end

    assign o_push = r_b_valid && r_b_emit;

endmodule

// ===== design/wmf_queue.sv =====
// ----------------------------------------------------------------------------
// wmf_queue
// Small register queue between the window front and the median back.
// ----------------------------------------------------------------------------
module wmf_queue #(
    parameter int WIDTH = 240,
    parameter int DEPTH = wmf_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

// ===== design/wmf_back.sv =====
// ----------------------------------------------------------------------------
// wmf_back
// Rank-based median selection per channel with a stallable output register.
// ----------------------------------------------------------------------------
module wmf_back #(
    parameter int WIN_H = wmf_pkg::DEF_WIN_H,
    parameter int WIN_W = wmf_pkg::DEF_WIN_W
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_pop,
    input  logic [WIN_H*WIN_W*wmf_pkg::PIX_W+wmf_pkg::META_W-1:0] i_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [wmf_pkg::CH_W-1:0]                o_med_ch0,
    output logic [wmf_pkg::CH_W-1:0]                o_med_ch1,
    output logic [wmf_pkg::CH_W-1:0]                o_med_ch2,
    output logic [wmf_pkg::POS_W-1:0]               o_center_row,
    output logic [wmf_pkg::POS_W-1:0]               o_center_col,
    output logic                                    o_frame_end
);

    localparam int WIN_N = WIN_H * WIN_W;
    localparam int PW    = wmf_pkg::PIX_W;
    localparam int CW    = wmf_pkg::CH_W;
    localparam int NCH   = wmf_pkg::NUM_CH;

    logic                 r_s1_valid;
    logic [CW-1:0]        r_s1_val [NCH][WIN_N];
    logic [WIN_N-1:0]     r_s1_lt  [NCH][WIN_N];
    wmf_pkg::t_meta       r_s1_meta;

    logic                 r_out_valid;
    logic [CW-1:0]        r_med [NCH];
    wmf_pkg::t_meta       r_out_meta;

    logic [CW-1:0]        v    [NCH][WIN_N];
    logic [WIN_N-1:0]     lt   [NCH][WIN_N];
    logic [CW-1:0]        med  [NCH];
    logic                 en;

    assign en    = !r_out_valid || !i_out_stall;
    assign o_pop = en && i_valid;

    // comparison matrix: bit j of row i set when element j sorts before element i
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            for (int i = 0; i < WIN_N; i++) begin
                v[ch][i] = i_data[i*PW + ch*CW +: CW];
            end
            for (int i = 0; i < WIN_N; i++) begin
                for (int j = 0; j < WIN_N; j++) begin
                    if (j < i) begin
                        lt[ch][i][j] = v[ch][j] <= v[ch][i];
                    end else if (j > i) begin
                        lt[ch][i][j] = v[ch][j] < v[ch][i];
                    end else begin
                        lt[ch][i][j] = 1'b0;
                    end
                end
            end
        end
    end

    // pick the element whose rank is the middle one; channels 1 and 2 read zero when color mode is off
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            med[ch] = '0;
            for (int i = 0; i < WIN_N; i++) begin
                if ($countones(r_s1_lt[ch][i]) == WIN_N / 2) begin
                    med[ch] = med[ch] | r_s1_val[ch][i];
                end
            end
        end
        if (!r_s1_meta.color_mode) begin
            med[1] = '0;
            med[2] = '0;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_valid;
            r_out_valid <= r_s1_valid;
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_val   <= v;
            r_s1_lt    <= lt;
            r_s1_meta  <= i_data[WIN_N*PW +: wmf_pkg::META_W];
            r_med      <= med;
            r_out_meta <= r_s1_meta;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_med_ch0    = r_med[0];
    assign o_med_ch1    = r_med[1];
    assign o_med_ch2    = r_med[2];
    assign o_center_row = r_out_meta.center_row;
    assign o_center_col = r_out_meta.center_col;
    assign o_frame_end  = r_out_meta.frame_end;

endmodule

// ===== design/window_median_filter.sv =====
// ----------------------------------------------------------------------------
// window_median_filter
// Sliding-window median over a raster pixel stream, three 8-bit channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall takes one pixel per request in
//   raster order. Each pixel with a window wholly inside the frame yields
//   one result on o_out_valid / i_out_stall: the per-channel median, the
//   centre position and a frame-end flag. Border pixels yield nothing.
//   One pixel is taken per clock while o_in_stall is low; the line-store
//   read and window stage, the queue, the compare stage and the output
//   register lie between an accepted pixel and its result.
//   A four-entry queue sits between window front and median back. When
//   the receiver stalls, results collect there and the input stalls once
//   every queue entry is taken by a pending result.
//   Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set
//   frame width, height and color mode; write them only while idle.
//   Synchronous reset clears counters, queue and pipeline valids and sets
//   640 x 480 color mode. The line stores need no clearing pass.
// ----------------------------------------------------------------------------
module window_median_filter #(
    parameter int WIN_H     = wmf_pkg::DEF_WIN_H,
    parameter int WIN_W     = wmf_pkg::DEF_WIN_W,
    parameter int MAX_WIDTH = wmf_pkg::DEF_MAX_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [wmf_pkg::CH_W-1:0]    i_pix_ch0,
    input  logic [wmf_pkg::CH_W-1:0]    i_pix_ch1,
    input  logic [wmf_pkg::CH_W-1:0]    i_pix_ch2,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [wmf_pkg::CH_W-1:0]    o_med_ch0,
    output logic [wmf_pkg::CH_W-1:0]    o_med_ch1,
    output logic [wmf_pkg::CH_W-1:0]    o_med_ch2,
    output logic [wmf_pkg::POS_W-1:0]   o_center_row,
    output logic [wmf_pkg::POS_W-1:0]   o_center_col,
    output logic                        o_frame_end,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [wmf_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int QW = WIN_H * WIN_W * wmf_pkg::PIX_W + wmf_pkg::META_W;

    logic [wmf_pkg::CFG_W-1:0] r_frame_width, r_frame_height;
    logic                      r_color_mode;
    logic                      push, pop, q_valid;
    logic [QW-1:0]             push_data, q_data;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= wmf_pkg::RST_FRAME_WIDTH;
            r_frame_height <= wmf_pkg::RST_FRAME_HEIGHT;
            r_color_mode   <= wmf_pkg::RST_COLOR_MODE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                wmf_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                wmf_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                wmf_pkg::CFG_COLOR_MODE:   r_color_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // window front
    wmf_front #(
        .WIN_H     (WIN_H),
        .WIN_W     (WIN_W),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pix          ({i_pix_ch2, i_pix_ch1, i_pix_ch0}),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_color_mode   (r_color_mode),
        .i_pop          (pop),
        .o_push         (push),
        .o_push_data    (push_data)
    );

    // decoupling queue
    wmf_queue #(
        .WIDTH (QW),
        .DEPTH (wmf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // median back
    wmf_back #(
        .WIN_H (WIN_H),
        .WIN_W (WIN_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .o_pop        (pop),
        .i_data       (q_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_med_ch0    (o_med_ch0),
        .o_med_ch1    (o_med_ch1),
        .o_med_ch2    (o_med_ch2),
        .o_center_row (o_center_row),
        .o_center_col (o_center_col),
        .o_frame_end  (o_frame_end)
    );

endmodule
